// File: hdl/gci_pkg.sv
// ----------------------------------------------------------------------------
// gci_pkg
// Shared widths, codes and controller/datapath signal groups for the grid
// cost interpolator.
// ----------------------------------------------------------------------------
package gci_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int STATE_W = 32;
  localparam int COST_W  = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int DIST_W  = 32;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 64;
  localparam int IP_W    = 43;
  localparam int QBIG_B  = 40;
  localparam int STAT_W  = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [COUNT_W-1:0] POINTS_RESET = 7'd2;

  localparam logic signed [COST_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COST_W-1:0] OUT_MIN = 32'sh8000_0000;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_POINTS_IN_USE = 1'b0;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EQUAL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic load_query;
    logic scan_en;
    logic order_en;
    logic diff_en;
    logic mag_en;
    logic mul_en;
    logic div_en;
    logic round_en;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic exact;
  } stat_t;

endpackage

// File: hdl/gci_ifs.sv
// ----------------------------------------------------------------------------
// gci_ifs
// Valid/ready channels for grid items and interpolation results.
// ----------------------------------------------------------------------------
interface gci_item_if import gci_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [INDEX_W-1:0]        point_index;
  logic signed [STATE_W-1:0] point_state;
  logic signed [COST_W-1:0]  point_cost;
  logic signed [STATE_W-1:0] query_state;

  modport source (
    output valid, mode, point_index, point_state, point_cost, query_state,
    input  ready
  );
  modport sink (
    input  valid, mode, point_index, point_state, point_cost, query_state,
    output ready
  );
endinterface

interface gci_result_if import gci_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COST_W-1:0] cost_value;
  logic                     exact_hit;
  logic [STAT_W-1:0]        status;

  modport source (
    output valid, cost_value, exact_hit, status,
    input  ready
  );
  modport sink (
    input  valid, cost_value, exact_hit, status,
    output ready
  );
endinterface

// File: hdl/gci_ram.sv
// ----------------------------------------------------------------------------
// gci_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gci_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/gci_ctrl.sv
// ----------------------------------------------------------------------------
// gci_ctrl
// Sequencer for the grid cost interpolator: handshakes, scan, arithmetic
// steps and the result register's valid flag.
// ----------------------------------------------------------------------------
module gci_ctrl import gci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  logic  item_mode,
  output logic  item_ready,
  output logic  res_valid,
  input  logic  res_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam int STEP_W = $clog2(PROD_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ORDER,
    S_DIFF,
    S_MAG,
    S_MUL,
    S_DIV,
    S_ROUND,
    S_DONE
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   div_cnt;
  logic                take;

  assign item_ready = (state == S_IDLE);
  assign take       = (state == S_DONE) && (!res_valid || res_ready);

  always_comb begin
    cmd            = '0;
    cmd.wr_en      = (state == S_IDLE) && item_valid && (item_mode == MODE_WRITE);
    cmd.load_query = (state == S_IDLE) && item_valid && (item_mode == MODE_QUERY);
    cmd.scan_en    = (state == S_SCAN);
    cmd.order_en   = (state == S_ORDER);
    cmd.diff_en    = (state == S_DIFF);
    cmd.mag_en     = (state == S_MAG);
    cmd.mul_en     = (state == S_MUL);
    cmd.div_en     = (state == S_DIV);
    cmd.round_en   = (state == S_ROUND);
    cmd.res_load   = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load_query) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            state <= stat.exact ? S_DONE : S_ORDER;
          end
        end
        S_ORDER: state <= S_DIFF;
        S_DIFF:  state <= S_MAG;
        S_MAG:   state <= S_MUL;
        S_MUL: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == STEP_W'(PROD_W - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: state <= S_DONE;
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/gci_dp.sv
// ----------------------------------------------------------------------------
// gci_dp
// Datapath of the grid cost interpolator: point store, nearest-pair scan,
// multiplier, restoring divider, rounding and saturation.
// ----------------------------------------------------------------------------
module gci_dp import gci_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [INDEX_W-1:0]        wr_index,
  input  logic signed [STATE_W-1:0] wr_state,
  input  logic signed [COST_W-1:0]  wr_cost,
  input  logic signed [STATE_W-1:0] query,
  input  logic [COUNT_W-1:0]        points_in_use,
  output logic signed [COST_W-1:0]  res_cost,
  output logic                      res_hit,
  output logic [STAT_W-1:0]         res_status
);

  localparam int AW      = $clog2(MAX_POINTS);
  localparam int CW      = ($clog2(MAX_POINTS + 1) > COUNT_W) ?
                           $clog2(MAX_POINTS + 1) : COUNT_W;
  localparam int ENTRY_W = STATE_W + COST_W;

  localparam logic signed [IP_W-1:0] RES_MAX = IP_W'(OUT_MAX);
  localparam logic signed [IP_W-1:0] RES_MIN = IP_W'(OUT_MIN);

  logic                      ram_wr;
  logic [ENTRY_W-1:0]        rd_data;
  logic [CW-1:0]             n_cfg;
  logic [CW-1:0]             n_eff;

  logic signed [STATE_W-1:0] q;
  logic [AW-1:0]             n_last;
  logic [AW-1:0]             rd_addr;
  logic                      v1;
  logic                      first1;
  logic                      v2;
  logic                      first2;
  logic [DIST_W-1:0]         dist2;
  logic signed [STATE_W-1:0] st2;
  logic signed [COST_W-1:0]  ct2;

  logic signed [STATE_W-1:0] rd_state;
  logic [DIFF_W-1:0]         dpos;
  logic [DIFF_W-1:0]         dneg;
  logic [DIST_W-1:0]         dist1;

  logic [DIST_W-1:0]         best_d;
  logic signed [STATE_W-1:0] best_s;
  logic signed [COST_W-1:0]  best_c;
  logic [DIST_W-1:0]         sec_d;
  logic signed [STATE_W-1:0] sec_s;
  logic signed [COST_W-1:0]  sec_c;
  logic                      sec_v;

  logic signed [STATE_W-1:0] s1;
  logic signed [STATE_W-1:0] s2;
  logic signed [COST_W-1:0]  c1;
  logic signed [COST_W-1:0]  c2;
  logic signed [DIFF_W-1:0]  d;
  logic signed [DIFF_W-1:0]  a;
  logic signed [DIFF_W-1:0]  b;
  logic [DIFF_W-1:0]         nd;
  logic [DIFF_W-1:0]         na;
  logic [DIFF_W-1:0]         nb;
  logic [DIST_W-1:0]         ud;
  logic [DIST_W-1:0]         ma;
  logic [DIST_W-1:0]         mb;
  logic                      neg;
  logic                      deq;

  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         num;
  logic [DIST_W-1:0]         rem;
  logic [DIFF_W-1:0]         rem_sh;
  logic [DIFF_W-1:0]         rem_sub;
  logic                      q_bit;

  logic signed [IP_W-1:0]    c2x;
  logic signed [IP_W-1:0]    qx;
  logic signed [IP_W-1:0]    ip;
  logic                      big;
  logic                      rge;
  logic                      rgt;
  logic                      adj;
  logic signed [IP_W-1:0]    res;

  assign ram_wr = cmd.wr_en && (CW'(wr_index) < CW'(MAX_POINTS));

  gci_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (AW'(wr_index)),
    .wr_data ({wr_state, wr_cost}),
    .rd_en   (cmd.scan_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign n_cfg = CW'(points_in_use);

  always_comb begin
    if (n_cfg < CW'(2)) begin
      n_eff = CW'(2);
    end else if (n_cfg > CW'(MAX_POINTS)) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = n_cfg;
    end
  end

  assign rd_state = $signed(rd_data[ENTRY_W-1:COST_W]);
  assign dpos     = {rd_state[STATE_W-1], rd_state} - {q[STATE_W-1], q};
  assign dneg     = {q[STATE_W-1], q} - {rd_state[STATE_W-1], rd_state};
  assign dist1    = dpos[DIFF_W-1] ? dneg[DIST_W-1:0] : dpos[DIST_W-1:0];

  assign stat.scan_last = (rd_addr == n_last);
  assign stat.pipe_busy = v1 || v2;
  assign stat.exact     = (best_d == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      sec_v <= 1'b0;
    end else begin
      v1 <= cmd.scan_en;
      v2 <= v1;
      if (v2) begin
        if (first2) begin
          sec_v <= 1'b0;
        end else if ((dist2 < best_d) || !sec_v || (dist2 < sec_d)) begin
          sec_v <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q       <= query;
      n_last  <= AW'(n_eff - CW'(1));
      rd_addr <= '0;
    end else if (cmd.scan_en) begin
      rd_addr <= rd_addr + 1'b1;
    end
    first1 <= (rd_addr == '0);
    first2 <= first1;
    dist2  <= dist1;
    st2    <= rd_state;
    ct2    <= $signed(rd_data[COST_W-1:0]);
    if (v2) begin
      if (first2) begin
        best_d <= dist2;
        best_s <= st2;
        best_c <= ct2;
      end else if (dist2 < best_d) begin
        sec_d  <= best_d;
        sec_s  <= best_s;
        sec_c  <= best_c;
        best_d <= dist2;
        best_s <= st2;
        best_c <= ct2;
      end else if (!sec_v || (dist2 < sec_d)) begin
        sec_d <= dist2;
        sec_s <= st2;
        sec_c <= ct2;
      end
    end
  end

  assign nd = '0 - d;
  assign na = '0 - a;
  assign nb = '0 - b;
  assign prod = ma * mb;

  assign rem_sh  = {rem, num[PROD_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, ud});
  assign rem_sub = rem_sh - {1'b0, ud};

  assign c2x = IP_W'(c2);
  assign qx  = $signed({{(IP_W - QBIG_B - 1){1'b0}}, num[QBIG_B:0]});

  always_ff @(posedge clk) begin
    if (cmd.order_en) begin
      if (best_s < sec_s) begin
        s1 <= best_s;
        c1 <= best_c;
        s2 <= sec_s;
        c2 <= sec_c;
      end else begin
        s1 <= sec_s;
        c1 <= sec_c;
        s2 <= best_s;
        c2 <= best_c;
      end
    end
    if (cmd.diff_en) begin
      d <= DIFF_W'(s1) - DIFF_W'(s2);
      a <= DIFF_W'(c1) - DIFF_W'(c2);
      b <= DIFF_W'(q) - DIFF_W'(s2);
    end
    if (cmd.mag_en) begin
      ud  <= d[DIFF_W-1] ? nd[DIST_W-1:0] : d[DIST_W-1:0];
      ma  <= a[DIFF_W-1] ? na[DIST_W-1:0] : a[DIST_W-1:0];
      mb  <= b[DIFF_W-1] ? nb[DIST_W-1:0] : b[DIST_W-1:0];
      neg <= (a[DIFF_W-1] ^ b[DIFF_W-1]) ^ d[DIFF_W-1];
      deq <= (d == '0);
    end
    if (cmd.mul_en) begin
      num <= prod;
      rem <= '0;
    end else if (cmd.div_en) begin
      rem <= q_bit ? rem_sub[DIST_W-1:0] : rem_sh[DIST_W-1:0];
      num <= {num[PROD_W-2:0], q_bit};
    end
    if (cmd.round_en) begin
      big <= (|num[PROD_W-1:QBIG_B+1]) || (num[QBIG_B] && (|num[QBIG_B-1:0]));
      ip  <= neg ? (c2x - qx) : (c2x + qx);
      rge <= ({rem, 1'b0} >= {1'b0, ud});
      rgt <= ({rem, 1'b0} >  {1'b0, ud});
    end
  end

  always_comb begin
    if (!neg) begin
      adj = ip[IP_W-1] ? rgt : rge;
    end else begin
      adj = (!ip[IP_W-1] && (ip != '0)) ? rgt : rge;
    end
    res = neg ? (ip - IP_W'(adj)) : (ip + IP_W'(adj));
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (stat.exact) begin
        res_cost   <= best_c;
        res_hit    <= 1'b1;
        res_status <= STATUS_OK;
      end else if (deq) begin
        res_cost   <= '0;
        res_hit    <= 1'b0;
        res_status <= STATUS_EQUAL;
      end else if (big) begin
        res_cost   <= neg ? OUT_MIN : OUT_MAX;
        res_hit    <= 1'b0;
        res_status <= STATUS_SAT;
      end else if (res > RES_MAX) begin
        res_cost   <= OUT_MAX;
        res_hit    <= 1'b0;
        res_status <= STATUS_SAT;
      end else if (res < RES_MIN) begin
        res_cost   <= OUT_MIN;
        res_hit    <= 1'b0;
        res_status <= STATUS_SAT;
      end else begin
        res_cost   <= res[COST_W-1:0];
        res_hit    <= 1'b0;
        res_status <= STATUS_OK;
      end
    end
  end

endmodule

// File: hdl/grid_cost_interpolator.sv
// ----------------------------------------------------------------------------
// grid_cost_interpolator
// Grid of (state, cost) points with exact lookup and linear interpolation.
// ----------------------------------------------------------------------------
// A write item stores one grid point. A query item scans the first
// points_in_use points, clamped to 2..MAX_POINTS, one per cycle through the
// point RAM's single read port, keeping the two nearest points, and then
// works through ordering, differences, magnitudes, a multiply and a divider
// that yields one quotient bit per cycle, then rounding and saturation; an
// exact hit skips the arithmetic. One query is in progress at a time, and
// a finished result is held in an output register so that the next item can be
// accepted while it waits for transfer. The point store is not cleared at reset.
module grid_cost_interpolator import gci_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  gci_item_if.sink          item,
  gci_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [COUNT_W-1:0] points_in_use;
  cmd_t               cmd;
  stat_t              stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POINTS_IN_USE) ? APB_DW'(points_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= POINTS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_POINTS_IN_USE)) begin
      points_in_use <= pwdata[COUNT_W-1:0];
    end
  end

  gci_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.mode),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  gci_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .wr_index      (item.point_index),
    .wr_state      (item.point_state),
    .wr_cost       (item.point_cost),
    .query         (item.query_state),
    .points_in_use (points_in_use),
    .res_cost      (result.cost_value),
    .res_hit       (result.exact_hit),
    .res_status    (result.status)
  );

endmodule

// File: tb/sv/gci_cost_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gci_cost_checker
// Watches the item, result and register channels of the grid cost
// interpolator. It keeps its own copy of the grid and of the point count, and
// works out the answer to each query as it is transferred. Each result is
// compared with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module gci_cost_checker import gci_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  gci_item_if               item,
  gci_result_if             result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                errors,
  output int                pending
);

  localparam logic [APB_AW-1:0] POINTS_ADDR = APB_AW'(4 * REG_POINTS_IN_USE);
  localparam longint COST_HI = 64'sd2147483647;
  localparam longint COST_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic                     hit;
    logic [STAT_W-1:0]        st;
  } cost_answer_t;

  logic signed [STATE_W-1:0] grid_state_m [MAX_POINTS_DEF];
  logic signed [COST_W-1:0]  grid_cost_m  [MAX_POINTS_DEF];
  logic [COUNT_W-1:0]        points_cfg;
  cost_answer_t              cost_answers [$];

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned gap_to(input int idx, input longint q);
    return magnitude(longint'(grid_state_m[idx]) - q);
  endfunction

  function automatic cost_answer_t interpolate_cost(input logic signed [STATE_W-1:0] query);
    cost_answer_t      ans;
    int                n, i, best, second, lo, hi;
    longint            q, s1, s2, c1, c2, a, b, d, ip, res;
    longint unsigned   ud, num, qd, r;
    logic              neg;
    n = int'(points_cfg);
    if (n < 2) n = 2;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    q = longint'(query);
    ans.cost = '0;
    ans.hit = 1'b0;
    ans.st = STATUS_OK;
    for (i = 0; i < n; i++) begin
      if (longint'(grid_state_m[i]) == q) begin
        ans.cost = grid_cost_m[i];
        ans.hit = 1'b1;
        return ans;
      end
    end
    best = 0;
    for (i = 1; i < n; i++) begin
      if (gap_to(i, q) < gap_to(best, q)) best = i;
    end
    second = -1;
    for (i = 0; i < n; i++) begin
      if (i != best && (second < 0 || gap_to(i, q) < gap_to(second, q))) second = i;
    end
    if (grid_state_m[best] < grid_state_m[second]) begin
      lo = best;
      hi = second;
    end else begin
      lo = second;
      hi = best;
    end
    s1 = grid_state_m[lo];
    s2 = grid_state_m[hi];
    c1 = grid_cost_m[lo];
    c2 = grid_cost_m[hi];
    d = s1 - s2;
    if (d == 0) begin
      ans.st = STATUS_EQUAL;
      return ans;
    end
    a = c1 - c2;
    b = q - s2;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    ud = magnitude(d);
    num = magnitude(a) * magnitude(b);
    qd = num / ud;
    r = num % ud;
    if (qd > (64'd1 << QBIG_B)) begin
      res = neg ? COST_LO - 1 : COST_HI + 1;
    end else begin
      ip = c2 + (neg ? -$signed(qd) : $signed(qd));
      if (!neg) begin
        if (ip >= 0) res = ip + (((r << 1) >= ud) ? 1 : 0);
        else res = ip + (((r << 1) > ud) ? 1 : 0);
      end else begin
        if (ip > 0) res = ip - (((r << 1) > ud) ? 1 : 0);
        else res = ip - (((r << 1) >= ud) ? 1 : 0);
      end
    end
    if (res > COST_HI) begin
      res = COST_HI;
      ans.st = STATUS_SAT;
    end else if (res < COST_LO) begin
      res = COST_LO;
      ans.st = STATUS_SAT;
    end
    ans.cost = res[COST_W-1:0];
    return ans;
  endfunction

  always @(posedge clk) begin
    cost_answer_t got, want;
    if (rst) begin
      points_cfg = POINTS_RESET;
      cost_answers.delete();
      errors = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.cost = result.cost_value;
        got.hit = result.exact_hit;
        got.st = result.status;
        if (cost_answers.size() == 0) begin
          $display("%0t: unexpected result: cost %0d hit %0b status %0d",
                   $time, got.cost, got.hit, got.st);
          errors++;
        end else begin
          want = cost_answers.pop_front();
          if (got !== want) begin
            $display("%0t: expected cost %0d hit %0b status %0d, got cost %0d hit %0b status %0d",
                     $time, want.cost, want.hit, want.st, got.cost, got.hit, got.st);
            errors++;
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.mode == MODE_WRITE) begin
          grid_state_m[item.point_index] = item.point_state;
          grid_cost_m[item.point_index] = item.point_cost;
        end else begin
          cost_answers.insert(cost_answers.size(), interpolate_cost(item.query_state));
        end
      end
      if (psel && penable && pwrite && pready && paddr == POINTS_ADDR) begin
        points_cfg = pwdata[COUNT_W-1:0];
      end
    end
    pending = cost_answers.size();
  end

endmodule

// File: tb/sv/tb_grid_cost_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_cost_interpolator
// Drives grid writes and cost queries into the grid cost interpolator under
// several point counts, with random gaps on both channels, and leaves the
// checking to the cost checker beside the block.
// ----------------------------------------------------------------------------
module tb_grid_cost_interpolator;
  import gci_pkg::*;

  localparam logic [APB_AW-1:0] POINTS_ADDR = APB_AW'(4 * REG_POINTS_IN_USE);
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 180;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending_count;
  int                quiet_cycles;
  int                span;
  bit                calm;
  logic signed [STATE_W-1:0] shadow_states [MAX_POINTS_DEF];

  gci_item_if   item_ch ();
  gci_result_if cost_ch ();

  grid_cost_interpolator u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (cost_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gci_cost_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (cost_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (fail_count),
    .pending (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (cost_ch.valid && cost_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cost_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        cost_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      cost_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40)) @(negedge clk);
    end
  end

  function automatic logic signed [STATE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return (int'($urandom_range(0, 40)) - 20) * 1000;
      3, 4:    return int'($urandom_range(0, 200000)) - 100000;
      5, 6:    return $urandom;
      7: begin
        case ($urandom_range(0, 3))
          0:       return OUT_MIN;
          1:       return OUT_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic send_item(input logic m, input logic [INDEX_W-1:0] idx,
                           input logic signed [STATE_W-1:0] ps,
                           input logic signed [COST_W-1:0] pc,
                           input logic signed [STATE_W-1:0] qs);
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode <= m;
    item_ch.point_index <= idx;
    item_ch.point_state <= ps;
    item_ch.point_cost <= pc;
    item_ch.query_state <= qs;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_point(input logic [INDEX_W-1:0] idx,
                             input logic signed [STATE_W-1:0] s,
                             input logic signed [COST_W-1:0] c);
    shadow_states[idx] = s;
    send_item(MODE_WRITE, idx, s, c, $urandom);
  endtask

  task automatic ask_cost(input logic signed [STATE_W-1:0] q);
    send_item(MODE_QUERY, INDEX_W'($urandom), $urandom, $urandom, q);
  endtask

  task automatic settle_block();
    item_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_points(input int v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= POINTS_ADDR;
    pwdata <= APB_DW'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    span = (v < 2) ? 2 : ((v > MAX_POINTS_DEF) ? MAX_POINTS_DEF : v);
  endtask

  task automatic random_item();
    int k;
    logic signed [STATE_W-1:0] q;
    if ($urandom_range(0, 1) == 0) begin
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
      write_point(k[INDEX_W-1:0], pick_value(), pick_value());
    end else begin
      k = $urandom_range(0, span - 1);
      case ($urandom_range(0, 2))
        0: q = shadow_states[k];
        1: begin
          if ($urandom_range(0, 1) == 0) q = shadow_states[k] + int'($urandom_range(0, 6)) - 3;
          else q = shadow_states[k] + int'($urandom_range(0, 3000)) - 1500;
        end
        default: q = pick_value();
      endcase
      ask_cost(q);
    end
  endtask

  initial begin
    int cfg_plan [8];
    int ph, i;
    cfg_plan = '{64, 2, 127, 1, 17, 0, 65, 2};
    cfg_plan[7] = $urandom_range(2, 64);
    calm = 1'b0;
    span = 2;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_WRITE;
    item_ch.point_index = '0;
    item_ch.point_state = '0;
    item_ch.point_cost = '0;
    item_ch.query_state = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Two points at the reset count: extremes, duplicate states, saturation
    // and rounding of halves in both directions.
    write_point(0, OUT_MIN, OUT_MAX);
    write_point(1, OUT_MAX, OUT_MIN);
    ask_cost(OUT_MIN);
    ask_cost(OUT_MAX);
    ask_cost(0);
    ask_cost(-1);
    write_point(1, OUT_MIN, 5);
    ask_cost(OUT_MIN);
    ask_cost(0);
    write_point(0, 0, 0);
    write_point(1, 1, OUT_MAX);
    ask_cost(OUT_MAX);
    ask_cost(OUT_MIN);
    write_point(1, 2, 1);
    ask_cost(1);
    ask_cost(-1);
    ask_cost(3);
    ask_cost(-3);
    write_point(1, 2000, -1);
    ask_cost(1000);
    ask_cost(-1000);
    settle_block();

    for (ph = 0; ph < 8; ph++) begin
      set_points(cfg_plan[ph]);
      if (ph == 0) begin
        for (i = 0; i < MAX_POINTS_DEF; i++) write_point(i[INDEX_W-1:0], pick_value(), pick_value());
      end
      if (ph == 7) calm = 1'b1;
      repeat (PHASE_ITEMS) random_item();
      settle_block();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
